FILE: rtl/core/rtpst_pkg.sv
// ----------------------------------------------------------------------------
// rtpst_pkg
// Shared types and constants of the RTP receive stream tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpst_pkg;

	// default parameter values
	localparam int STREAM_SLOTS_DEF   = 16;
	localparam int DROPOUT_LIMIT_DEF  = 3000;
	localparam int MISORDER_LIMIT_DEF = 100;

	localparam int SLOT_IN_W = 4;
	localparam int HDR_W     = 19;
	localparam int HDR_MIN   = 12;
	localparam int SEQ_SPAN  = 65536;

	typedef logic [HDR_W-1:0] hdr_len_t;

	typedef enum logic [2:0] {
		VERDICT_OK      = 3'd0,
		VERDICT_CPU     = 3'd1,
		VERDICT_DROP    = 3'd2,
		VERDICT_UNKNOWN = 3'd3,
		VERDICT_TYPE    = 3'd4,
		VERDICT_SETUP   = 3'd5
	} verdict_t;

	// per-stream table entry
	typedef struct packed {
		logic        slot_valid;
		logic [6:0]  expected_type;
		logic        seq_started;
		logic [15:0] highest_seq;
		logic [15:0] resync_seq;
		logic        resync_armed;
		logic [31:0] rollover_count;
		logic [31:0] last_transit;
		logic [31:0] jitter_value;
	} entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/rtpst_pkt_if.sv
// ----------------------------------------------------------------------------
// rtpst_pkt_if
// Input channel: one packet summary or stream set-up per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpst_pkt_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [3:0]  stream_slot;
	logic [7:0]  first_byte;
	logic [6:0]  payload_type;
	logic [15:0] sequence_number;
	logic [31:0] rtp_timestamp;
	logic [31:0] arrival_units;
	logic [15:0] packet_length;
	logic [15:0] extension_words;

	modport source (
		output valid, mode, stream_slot, first_byte, payload_type, sequence_number,
		       rtp_timestamp, arrival_units, packet_length, extension_words,
		input  ready
	);
	modport sink (
		input  valid, mode, stream_slot, first_byte, payload_type, sequence_number,
		       rtp_timestamp, arrival_units, packet_length, extension_words,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/rtpst_res_if.sv
// ----------------------------------------------------------------------------
// rtpst_res_if
// Output channel: one verdict with header length, index and jitter.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpst_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [18:0] header_length;
	logic [47:0] packet_index;
	logic [31:0] jitter_estimate;

	modport source (
		output valid, verdict, header_length, packet_index, jitter_estimate,
		input  ready
	);
	modport sink (
		input  valid, verdict, header_length, packet_index, jitter_estimate,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/rtp_receive_stream_tracker_core.sv
// Input is registered into stage 1 and the table read register; the update
// goes to the result register once the output is free. A new item is taken
// only after the last is done, set by the read-modify-write of the slot entry
// in the single-port stream table. Reset: arst_n clears control state, then a
// clearing pass zeroes the stream table; no input is taken during the pass.
// ----------------------------------------------------------------------------
// rtp_receive_stream_tracker_core
// Per-stream RTP sequence rollover, resync and interarrival jitter tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_receive_stream_tracker_core #(
	parameter int STREAM_SLOTS   = rtpst_pkg::STREAM_SLOTS_DEF,
	parameter int DROPOUT_LIMIT  = rtpst_pkg::DROPOUT_LIMIT_DEF,
	parameter int MISORDER_LIMIT = rtpst_pkg::MISORDER_LIMIT_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rtpst_pkt_if.sink   pkt,
	rtpst_res_if.source res
);

	localparam int SLOT_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
	localparam int ADDR_X = (SLOT_W > rtpst_pkg::SLOT_IN_W) ? SLOT_W : rtpst_pkg::SLOT_IN_W;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_WORK  = 3'b100
	} state_t;

	state_t state_q;

	rtpst_pkg::entry_t mem [STREAM_SLOTS];
	rtpst_pkg::entry_t rd_q;
	rtpst_pkg::entry_t wd;
	logic              we;
	logic [SLOT_W-1:0] wa;
	logic [SLOT_W-1:0] clr_idx_q;

	// ---------------- input side ----------------
	logic              acc;
	logic [ADDR_X-1:0] slot_x;
	logic [SLOT_W-1:0] addr_in;
	logic              in_range;
	logic              not_rtp;
	rtpst_pkg::hdr_len_t len_x, hl_base, hl_ext, hl;

	assign pkt.ready = (state_q == ST_IDLE);
	assign acc       = pkt.valid && pkt.ready;
	assign slot_x    = ADDR_X'(pkt.stream_slot);
	assign addr_in   = slot_x[SLOT_W-1:0];
	assign in_range  = (32'(pkt.stream_slot) < 32'(STREAM_SLOTS));

	always_comb begin
		len_x   = rtpst_pkg::hdr_len_t'(pkt.packet_length);
		hl_base = rtpst_pkg::hdr_len_t'(rtpst_pkg::HDR_MIN)
			+ (rtpst_pkg::hdr_len_t'(pkt.first_byte[3:0]) << 2);
		hl_ext  = rtpst_pkg::hdr_len_t'(rtpst_pkg::HDR_MIN)
			+ ((rtpst_pkg::hdr_len_t'(pkt.first_byte[3:0])
			+ rtpst_pkg::hdr_len_t'(pkt.extension_words)
			+ rtpst_pkg::hdr_len_t'(1)) << 2);
		hl      = ((len_x >= hl_base) && pkt.first_byte[4]) ? hl_ext : hl_base;
		not_rtp = (pkt.packet_length < 16'(rtpst_pkg::HDR_MIN))
			|| (pkt.first_byte[7:6] != 2'b10);
	end

	// stage 1 payload
	logic                mode_s1;
	logic                in_range_s1;
	logic [SLOT_W-1:0]   addr_s1;
	logic [6:0]          pt_s1;
	logic [15:0]         seq_s1;
	logic [31:0]         transit_s1;
	logic                not_rtp_s1;
	logic                short_s1;
	rtpst_pkg::hdr_len_t hl_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1     <= pkt.mode;
			in_range_s1 <= in_range;
			addr_s1     <= addr_in;
			pt_s1       <= pkt.payload_type;
			seq_s1      <= pkt.sequence_number;
			transit_s1  <= pkt.arrival_units - pkt.rtp_timestamp;
			not_rtp_s1  <= not_rtp;
			short_s1    <= (len_x < hl);
			hl_s1       <= hl;
		end
	end

	// ---------------- table ----------------
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (acc) begin
			rd_q <= mem[addr_in];
		end
	end

	// ---------------- update ----------------
	logic                 out_valid_q;
	logic                 adv;
	rtpst_pkg::verdict_t  verdict;
	rtpst_pkg::entry_t    upd;
	logic                 first;
	logic [15:0]          udelta;
	logic [31:0]          diff, dabs;
	rtpst_pkg::hdr_len_t  hl_out;
	logic                 ok;

	assign adv = (state_q == ST_WORK) && (!out_valid_q || res.ready);

	always_comb begin
		priority if (mode_s1) begin
			verdict = rtpst_pkg::VERDICT_SETUP;
		end else if (not_rtp_s1) begin
			verdict = rtpst_pkg::VERDICT_CPU;
		end else if (short_s1) begin
			verdict = rtpst_pkg::VERDICT_DROP;
		end else if (!in_range_s1 || !rd_q.slot_valid) begin
			verdict = rtpst_pkg::VERDICT_UNKNOWN;
		end else if (pt_s1 != rd_q.expected_type) begin
			verdict = rtpst_pkg::VERDICT_TYPE;
		end else begin
			verdict = rtpst_pkg::VERDICT_OK;
		end
		ok     = (verdict == rtpst_pkg::VERDICT_OK);
		hl_out = (mode_s1 || not_rtp_s1) ? '0 : hl_s1;

		first  = !rd_q.seq_started;
		udelta = seq_s1 - rd_q.highest_seq;
		upd    = rd_q;
		if (first) begin
			upd.highest_seq    = seq_s1;
			upd.resync_armed   = 1'b0;
			upd.rollover_count = '0;
			upd.seq_started    = 1'b1;
		end else if ({1'b0, udelta} < 17'(DROPOUT_LIMIT)) begin
			if (seq_s1 < rd_q.highest_seq) begin
				upd.rollover_count = rd_q.rollover_count + 32'd1;
			end
			upd.highest_seq = seq_s1;
		end else if ({1'b0, udelta} <= 17'(rtpst_pkg::SEQ_SPAN - MISORDER_LIMIT)) begin
			if (rd_q.resync_armed && (seq_s1 == rd_q.resync_seq)) begin
				upd.highest_seq    = seq_s1;
				upd.resync_armed   = 1'b0;
				upd.rollover_count = '0;
			end else begin
				upd.resync_seq   = seq_s1 + 16'd1;
				upd.resync_armed = 1'b1;
			end
		end

		// jitter kept scaled by 16
		diff              = transit_s1 - rd_q.last_transit;
		dabs              = diff[31] ? (32'd0 - diff) : diff;
		upd.last_transit  = transit_s1;
		if (!first) begin
			upd.jitter_value = rd_q.jitter_value + dabs - ((rd_q.jitter_value + 32'd8) >> 4);
		end

		// table write: clearing pass, set-up or accepted packet
		wa = addr_s1;
		wd = upd;
		we = 1'b0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wa = clr_idx_q;
			wd = '0;
		end else if (adv && mode_s1) begin
			we               = in_range_s1;
			wd               = '0;
			wd.slot_valid    = 1'b1;
			wd.expected_type = pt_s1;
		end else if (adv && ok) begin
			we = 1'b1;
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + SLOT_W'(1);
					if (clr_idx_q == SLOT_W'(STREAM_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_WORK;
					end
				end
				ST_WORK: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- result register ----------------
	rtpst_pkg::verdict_t verdict_q;
	rtpst_pkg::hdr_len_t hl_q;
	logic [47:0]         index_q;
	logic [31:0]         jitter_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			verdict_q <= verdict;
			hl_q      <= hl_out;
			index_q   <= ok ? {upd.rollover_count, seq_s1} : '0;
			jitter_q  <= ok ? upd.jitter_value : '0;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.verdict         = verdict_q;
	assign res.header_length   = hl_q;
	assign res.packet_index    = index_q;
	assign res.jitter_estimate = jitter_q;

endmodule

`default_nettype wire

FILE: test/tb_rtp_receive_stream_tracker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtp_receive_stream_tracker_core
// Self-checking bench for the RTP receive stream tracker. A queue-fed driver
// pushes packet summaries and stream set-ups. Each accepted transfer runs
// through a local model of the stream table (classification, header length,
// sequence rollover and resync, interarrival jitter). A monitor compares each
// returned verdict against the oldest prediction. Directed corner cases come
// first, then random stream traffic with noise over three back-pressure
// phases.
// ----------------------------------------------------------------------------

module tb_rtp_receive_stream_tracker_core;
	import rtpst_pkg::*;

	localparam logic [7:0] RTP_V2_LO   = 8'd128;
	localparam logic [7:0] RTP_V2_HI   = 8'd191;
	localparam int         STALL_LIMIT = 5000;

	typedef struct {
		logic        mode;
		logic [3:0]  stream_slot;
		logic [7:0]  first_byte;
		logic [6:0]  payload_type;
		logic [15:0] sequence_number;
		logic [31:0] rtp_timestamp;
		logic [31:0] arrival_units;
		logic [15:0] packet_length;
		logic [15:0] extension_words;
	} pkt_item_t;

	typedef struct {
		verdict_t    verdict;
		hdr_len_t    header_length;
		logic [47:0] packet_index;
		logic [31:0] jitter_estimate;
	} verdict_rec_t;

	logic clk;
	logic arst_n;

	rtpst_pkt_if pkt_ch ();
	rtpst_res_if res_ch ();

	rtp_receive_stream_tracker_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.res    (res_ch)
	);

	// local copy of the stream table
	entry_t       stream_tbl [STREAM_SLOTS_DEF];

	pkt_item_t    pkt_backlog [$];
	verdict_rec_t awaited_verdicts [$];
	pkt_item_t    on_wire;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           mismatches;
	int           stall_cycles;

	// random stream generator state
	bit           gen_live [16];
	logic [6:0]   gen_pt [16];
	logic [15:0]  gen_seq [16];
	logic [31:0]  gen_ts [16];
	logic [31:0]  gen_arr [16];
	bit           gen_resync_due [16];
	logic [15:0]  gen_resync_at [16];

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic verdict_rec_t judge_packet(input pkt_item_t it);
		verdict_rec_t r;
		entry_t       e;
		int unsigned  cc;
		int unsigned  hl;
		logic [15:0]  udelta;
		logic [31:0]  transit;
		logic [31:0]  diff;
		logic [31:0]  mag;
		logic         first;
		logic         in_range;

		r.verdict         = VERDICT_OK;
		r.header_length   = '0;
		r.packet_index    = '0;
		r.jitter_estimate = '0;
		in_range = (int'(it.stream_slot) < STREAM_SLOTS_DEF);

		if (it.mode) begin
			if (in_range) begin
				e = '0;
				e.slot_valid = 1'b1;
				e.expected_type = it.payload_type;
				stream_tbl[it.stream_slot] = e;
			end
			r.verdict = VERDICT_SETUP;
			return r;
		end

		if (it.packet_length < HDR_MIN || it.first_byte < RTP_V2_LO ||
		    it.first_byte > RTP_V2_HI) begin
			r.verdict = VERDICT_CPU;
			return r;
		end

		cc = 32'(it.first_byte[3:0]);
		hl = HDR_MIN + 4 * cc;
		// extension length only counts once the CSRC list itself fits
		if (it.packet_length >= hl && it.first_byte[4])
			hl = HDR_MIN + 4 * (cc + 1 + 32'(it.extension_words));
		r.header_length = hl[HDR_W-1:0];
		if (it.packet_length < hl) begin
			r.verdict = VERDICT_DROP;
			return r;
		end

		if (!in_range || !stream_tbl[it.stream_slot].slot_valid) begin
			r.verdict = VERDICT_UNKNOWN;
			return r;
		end
		if (it.payload_type != stream_tbl[it.stream_slot].expected_type) begin
			r.verdict = VERDICT_TYPE;
			return r;
		end

		e = stream_tbl[it.stream_slot];
		first = !e.seq_started;
		udelta = it.sequence_number - e.highest_seq;
		if (!e.seq_started) begin
			e.highest_seq = it.sequence_number;
			e.resync_armed = 1'b0;
			e.rollover_count = '0;
			e.seq_started = 1'b1;
		end else if (udelta < DROPOUT_LIMIT_DEF) begin
			if (it.sequence_number < e.highest_seq)
				e.rollover_count = e.rollover_count + 32'd1;
			e.highest_seq = it.sequence_number;
		end else if (udelta <= SEQ_SPAN - MISORDER_LIMIT_DEF) begin
			if (e.resync_armed && it.sequence_number == e.resync_seq) begin
				e.highest_seq = it.sequence_number;
				e.resync_armed = 1'b0;
				e.rollover_count = '0;
			end else begin
				e.resync_seq = it.sequence_number + 16'd1;
				e.resync_armed = 1'b1;
			end
		end
		// misordered packets leave the sequence state alone

		transit = it.arrival_units - it.rtp_timestamp;
		diff = transit - e.last_transit;
		mag = diff[31] ? (32'd0 - diff) : diff;
		e.last_transit = transit;
		if (!first)
			e.jitter_value = e.jitter_value + mag - ((e.jitter_value + 32'd8) >> 4);

		stream_tbl[it.stream_slot] = e;
		r.packet_index = {e.rollover_count, it.sequence_number};
		r.jitter_estimate = e.jitter_value;
		return r;
	endfunction

	function automatic pkt_item_t directed_item(input int m, input int slot,
		input int fb, input int pt, input int seq, input logic [31:0] ts,
		input logic [31:0] arr, input int len, input int xw);
		pkt_item_t it;

		it.mode = 1'(m);
		it.stream_slot = 4'(slot);
		it.first_byte = 8'(fb);
		it.payload_type = 7'(pt);
		it.sequence_number = 16'(seq);
		it.rtp_timestamp = ts;
		it.arrival_units = arr;
		it.packet_length = 16'(len);
		it.extension_words = 16'(xw);
		return it;
	endfunction

	task automatic queue_random(input int n);
		pkt_item_t   it;
		int unsigned slot;
		int unsigned pick;
		int unsigned roll;
		int unsigned cc;
		int unsigned hl;
		int unsigned ts_step;
		logic        ext;

		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			slot = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
			it.mode = 1'b0;
			it.stream_slot = 4'(slot);
			it.first_byte = 8'($urandom());
			it.payload_type = 7'($urandom());
			it.sequence_number = 16'($urandom());
			it.rtp_timestamp = $urandom();
			it.arrival_units = $urandom();
			it.packet_length = 16'($urandom());
			it.extension_words = 16'($urandom());

			if (pick < 12) begin
				// noise: everything random, now and then a random set-up
				it.mode = ($urandom_range(9) == 0);
				if (pick < 4)
					it.packet_length = 16'($urandom_range(0, 100));
				if (it.mode) begin
					gen_live[slot] = 1'b1;
					gen_pt[slot] = it.payload_type;
					gen_resync_due[slot] = 1'b0;
				end
			end else if (!gen_live[slot] || pick < 16) begin
				it.mode = 1'b1;
				gen_live[slot] = 1'b1;
				gen_pt[slot] = it.payload_type;
				gen_seq[slot] = $urandom_range(1) ? 16'(32'hFFFF - $urandom_range(0, 40)) :
					16'($urandom());
				gen_ts[slot] = $urandom();
				gen_arr[slot] = $urandom();
				gen_resync_due[slot] = 1'b0;
			end else begin
				cc = ($urandom_range(3) == 0) ? $urandom_range(15) : 0;
				ext = ($urandom_range(4) == 0);
				it.first_byte = 8'(32'h80 | ($urandom_range(1) << 5) | (32'(ext) << 4) | cc);
				if (ext)
					it.extension_words = 16'($urandom_range(0, 6));
				hl = HDR_MIN + 4 * cc + (ext ? 4 * (1 + 32'(it.extension_words)) : 0);
				it.packet_length = ($urandom_range(19) == 0) ? 16'(hl) :
					16'(hl + $urandom_range(0, 1400));
				it.payload_type = ($urandom_range(24) == 0) ? 7'($urandom()) : gen_pt[slot];

				roll = $urandom_range(99);
				if (gen_resync_due[slot] && roll < 70) begin
					it.sequence_number = gen_resync_at[slot];
					gen_seq[slot] = gen_resync_at[slot];
					gen_resync_due[slot] = 1'b0;
				end else if (roll < 70) begin
					gen_seq[slot] = gen_seq[slot] + 16'd1;
					it.sequence_number = gen_seq[slot];
				end else if (roll < 78) begin
					gen_seq[slot] = gen_seq[slot] + 16'($urandom_range(2, 20));
					it.sequence_number = gen_seq[slot];
				end else if (roll < 82) begin
					gen_seq[slot] = gen_seq[slot] + 16'($urandom_range(21, 2999));
					it.sequence_number = gen_seq[slot];
				end else if (roll < 90) begin
					// late packet: just misordered, or far enough back to arm resync
					it.sequence_number = gen_seq[slot] - 16'($urandom_range(1, 120));
				end else if (roll < 95) begin
					it.sequence_number = gen_seq[slot] + 16'($urandom_range(3000, 62000));
					gen_resync_due[slot] = 1'b1;
					gen_resync_at[slot] = it.sequence_number + 16'd1;
				end else begin
					it.sequence_number = gen_seq[slot];
				end

				ts_step = 160 * $urandom_range(0, 6);
				gen_ts[slot] = gen_ts[slot] + ts_step;
				gen_arr[slot] = ($urandom_range(19) == 0) ? 32'($urandom()) :
					gen_arr[slot] + ts_step + $urandom_range(0, 80);
				it.rtp_timestamp = gen_ts[slot];
				it.arrival_units = gen_arr[slot];
			end
			pkt_backlog.push_back(it);
		end
	endtask

	// driver: when the channel is free, loads the next summary unless a random idle draw holds it back
	always @(posedge clk) begin
		if (!arst_n) begin
			pkt_ch.valid <= 1'b0;
		end else begin
			if (pkt_ch.valid && pkt_ch.ready)
				awaited_verdicts.push_back(judge_packet(on_wire));
			if (!pkt_ch.valid || pkt_ch.ready) begin
				if (pkt_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_wire = pkt_backlog.pop_front();
					pkt_ch.valid <= 1'b1;
					pkt_ch.mode <= on_wire.mode;
					pkt_ch.stream_slot <= on_wire.stream_slot;
					pkt_ch.first_byte <= on_wire.first_byte;
					pkt_ch.payload_type <= on_wire.payload_type;
					pkt_ch.sequence_number <= on_wire.sequence_number;
					pkt_ch.rtp_timestamp <= on_wire.rtp_timestamp;
					pkt_ch.arrival_units <= on_wire.arrival_units;
					pkt_ch.packet_length <= on_wire.packet_length;
					pkt_ch.extension_words <= on_wire.extension_words;
				end else begin
					pkt_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer, throttles ready, runs the watchdog
	always @(posedge clk) begin
		verdict_rec_t want;

		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_cycles <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (awaited_verdicts.size() == 0) begin
					$error("result transfer with no prediction pending: verdict %0d",
						res_ch.verdict);
					mismatches++;
				end else begin
					want = awaited_verdicts.pop_front();
					if (res_ch.verdict !== want.verdict) begin
						$error("verdict: expected %0d, got %0d", want.verdict, res_ch.verdict);
						mismatches++;
					end
					if (res_ch.header_length !== want.header_length) begin
						$error("header_length: expected %0d, got %0d",
							want.header_length, res_ch.header_length);
						mismatches++;
					end
					if (res_ch.packet_index !== want.packet_index) begin
						$error("packet_index: expected 0x%012h, got 0x%012h",
							want.packet_index, res_ch.packet_index);
						mismatches++;
					end
					if (res_ch.jitter_estimate !== want.jitter_estimate) begin
						$error("jitter_estimate: expected 0x%08h, got 0x%08h",
							want.jitter_estimate, res_ch.jitter_estimate);
						mismatches++;
					end
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

			if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready) ||
			    (pkt_backlog.size() == 0 && !pkt_ch.valid && awaited_verdicts.size() == 0))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("rtp_receive_stream_tracker_core: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pkt_ch.valid = 1'b0;
		pkt_ch.mode = 1'b0;
		pkt_ch.stream_slot = '0;
		pkt_ch.first_byte = '0;
		pkt_ch.payload_type = '0;
		pkt_ch.sequence_number = '0;
		pkt_ch.rtp_timestamp = '0;
		pkt_ch.arrival_units = '0;
		pkt_ch.packet_length = '0;
		pkt_ch.extension_words = '0;
		res_ch.ready = 1'b0;
		mismatches = 0;
		stall_cycles = 0;
		send_idle_pct = 22;
		recv_idle_pct = 83;
		for (int s = 0; s < STREAM_SLOTS_DEF; s++)
			stream_tbl[s] = '0;
		// a noise set-up can make a slot live before its stream state is seeded
		for (int s = 0; s < 16; s++) begin
			gen_live[s] = 1'b0;
			gen_resync_due[s] = 1'b0;
			gen_pt[s] = '0;
			gen_seq[s] = '0;
			gen_ts[s] = '0;
			gen_arr[s] = '0;
			gen_resync_at[s] = '0;
		end

		// set-ups, then the classification corners
		pkt_backlog.push_back(directed_item(1, 0, 0, 96, 0, 0, 0, 0, 0));
		pkt_backlog.push_back(directed_item(1, 15, 'hFF, 127, 'hFFFF, '1, '1, 'hFFFF,
			'hFFFF));
		pkt_backlog.push_back(directed_item(1, 1, 0, 0, 0, 0, 0, 0, 0));
		pkt_backlog.push_back(directed_item(0, 0, 127, 96, 1, 0, 0, 100, 0));
		pkt_backlog.push_back(directed_item(0, 0, 192, 96, 1, 0, 0, 100, 0));
		pkt_backlog.push_back(directed_item(0, 0, 128, 96, 1, 0, 0, 11, 0));
		pkt_backlog.push_back(directed_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
		pkt_backlog.push_back(directed_item(0, 15, 255, 127, 0, 0, 0, 'hFFFF, 0));
		// CSRC list one byte too long, then the largest possible extension
		pkt_backlog.push_back(directed_item(0, 0, 'h8F, 96, 1, 0, 0, 71, 0));
		pkt_backlog.push_back(directed_item(0, 0, 'h9F, 96, 1, 0, 0, 'hFFFF, 'hFFFF));
		pkt_backlog.push_back(directed_item(0, 5, 'h90, 96, 1, 0, 0, 16, 0));
		pkt_backlog.push_back(directed_item(0, 0, 'h80, 97, 1, 0, 0, 12, 0));
		// slot 0: start, wrap, misorder, jump, resync
		pkt_backlog.push_back(directed_item(0, 0, 'h80, 96, 'hFFFF, 32'hFFFF_FFFF, 0, 12, 0));
		pkt_backlog.push_back(directed_item(0, 0, 'h80, 96, 0, 160, 200, 12, 0));
		pkt_backlog.push_back(directed_item(0, 0, 'h80, 96, 65500, 320, 350, 12, 0));
		pkt_backlog.push_back(directed_item(0, 0, 'h80, 96, 10000, 480, 700, 12, 0));
		pkt_backlog.push_back(directed_item(0, 0, 'h80, 96, 10001, 640, 650, 12, 0));
		pkt_backlog.push_back(directed_item(0, 0, 'h80, 96, 10002, 800, 900, 12, 0));
		pkt_backlog.push_back(directed_item(0, 15, 'hBF, 127, 0, 0, 32'hFFFF_FFFF,
			'hFFFF, 0));
		pkt_backlog.push_back(directed_item(0, 15, 'h9F, 127, 1, 1000, 0, 88, 3));
		// slot 1: dropout limit boundaries
		pkt_backlog.push_back(directed_item(0, 1, 'hA0, 0, 100, 0, 0, 1500, 0));
		pkt_backlog.push_back(directed_item(0, 1, 'h80, 0, 3099, 0, 0, 12, 0));
		pkt_backlog.push_back(directed_item(0, 1, 'h80, 0, 2999, 0, 0, 12, 0));
		pkt_backlog.push_back(directed_item(0, 1, 'h80, 0, 3100, 0, 0, 12, 0));
		// set-up again on a live slot clears its tracking
		pkt_backlog.push_back(directed_item(1, 0, 0, 96, 0, 0, 0, 0, 0));
		pkt_backlog.push_back(directed_item(0, 0, 'h80, 96, 5, 7, 9, 12, 0));

		queue_random(317);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 83;
				recv_idle_pct = 22;
				queue_random(317);
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				queue_random(316);
			end
			do
				@(posedge clk);
			while (pkt_backlog.size() != 0 || pkt_ch.valid || awaited_verdicts.size() != 0);
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("rtp_receive_stream_tracker_core: match");
		else
			$display("rtp_receive_stream_tracker_core: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/rtpst_pkg.sv
rtl/core/rtpst_pkt_if.sv
rtl/core/rtpst_res_if.sv
rtl/core/rtp_receive_stream_tracker_core.sv
test/tb_rtp_receive_stream_tracker_core.sv
